/* rtl/ir_drop_bounce_monitor_assert.svh */
// Assertion macros shared by the IR-drop bounce monitor RTL.
// The macros expect a clock named clk and an active-high reset named rst in scope.
// Defining NO_ASSERTIONS turns every macro into an empty statement.
`ifndef IR_DROP_BOUNCE_MONITOR_ASSERT_SVH
`define IR_DROP_BOUNCE_MONITOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define IDBM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ir drop bounce monitor assertion failed");
`define IDBM_ASSERT_NEXT(label, cond, after) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (after)) \
    else $error("ir drop bounce monitor assertion failed");
`else
`define IDBM_ASSERT(label, prop)
`define IDBM_ASSERT_NEXT(label, cond, after)
`endif

`endif

/* rtl/idbm_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, register indexes, reset values and types of the bounce monitor.
// No dependencies; every other RTL file imports this package.
package idbm_pkg;

  localparam int VOLT_W     = 23;
  localparam int CURR_W     = 24;
  localparam int LIFT_W     = 24;
  localparam int LIMIT_W    = 20;
  localparam int MARGIN_W   = 17;
  localparam int COUNT_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT      = 2'd2;

  localparam logic [LIMIT_W-1:0]  STEP_LIMIT_RST = 20'd25000;
  localparam logic [MARGIN_W-1:0] MARGIN_RST     = 17'd2000;
  localparam logic [COUNT_W-1:0]  COUNT_RST      = 8'd5;
  localparam logic [COUNT_W-1:0]  COUNT_CEIL     = 8'hFF;

  typedef struct packed {
    logic [LIMIT_W-1:0]  step_limit;
    logic [MARGIN_W-1:0] margin;
    logic [COUNT_W-1:0]  count_limit;
  } idbm_cfg_t;

  typedef struct packed {
    logic full;
    logic fault;
  } idbm_status_t;

endpackage

/* rtl/ir_drop_bounce_monitor.sv */
`timescale 1ns / 1ps
// IR-drop bounce monitor: one battery sample in, one status result out.
// Depends on idbm_pkg, idbm_track, idbm_mean and ir_drop_bounce_monitor_assert.svh.
//
// Usage:
//   Samples arrive on in_valid/in_stall with cell_voltage, cell_current and
//   no_charge; a transaction completes when in_valid is high and in_stall low.
//   Results leave on out_valid/out_stall with bounce_fault, window_full and
//   window_average, one result per sample, in order.
//   Registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data:
//   0 current step limit, 1 voltage margin, 2 count limit; other indexes are
//   ignored. cfg_ready is always high. Write them only while the block is idle.
//   Path: an accepted sample passes the input register, the state update and
//   the result register with the mean multiply before its result is valid.
//   Throughput: one sample per cycle while out_stall holds no result; the window
//   state is updated once per sample, so consecutive samples follow back to back.
//   Stall: when out_stall holds a result, the stages behind it keep filling and
//   in_stall rises only once all three stages hold a sample.
//   Reset (rst, synchronous) empties the pipeline, clears the window state, the
//   counters and the fault flag, and loads the register defaults.
`include "ir_drop_bounce_monitor_assert.svh"

module ir_drop_bounce_monitor import idbm_pkg::*; #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [VOLT_W-1:0]        cell_voltage,
  input  logic signed [CURR_W-1:0] cell_current,
  input  logic                     no_charge,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     bounce_fault,
  output logic                     window_full,
  output logic [VOLT_W-1:0]        window_average,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int SUM_W = VOLT_W + $clog2(WINDOW_LEN);

  idbm_cfg_t                cfg;
  logic                     in_full;
  logic [VOLT_W-1:0]        in_volt;
  logic signed [CURR_W-1:0] in_curr;
  logic                     in_nochg;
  logic                     mid_valid;
  logic                     out_open;
  logic                     mid_open;
  logic                     in_open;
  logic                     step;
  logic                     load;
  idbm_status_t             status;
  logic [SUM_W-1:0]         sum;

  assign out_open  = !out_valid || !out_stall;
  assign mid_open  = !mid_valid || out_open;
  assign in_open   = !in_full || mid_open;
  assign in_stall  = !in_open;
  assign step      = in_full && mid_open;
  assign load      = mid_valid && out_open;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full         <= 1'b0;
      mid_valid       <= 1'b0;
      out_valid       <= 1'b0;
      cfg.step_limit  <= STEP_LIMIT_RST;
      cfg.margin      <= MARGIN_RST;
      cfg.count_limit <= COUNT_RST;
    end else begin
      if (in_open) begin
        in_full <= in_valid;
      end
      if (mid_open) begin
        mid_valid <= in_full;
      end
      if (out_open) begin
        out_valid <= mid_valid;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_STEP_LIMIT: cfg.step_limit  <= cfg_data;
          REG_MARGIN:     cfg.margin      <= cfg_data[MARGIN_W-1:0];
          REG_COUNT:      cfg.count_limit <= cfg_data[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_open) begin
      in_volt  <= cell_voltage;
      in_curr  <= cell_current;
      in_nochg <= no_charge;
    end
  end

  idbm_track #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_track (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (step),
    .volt   (in_volt),
    .curr   (in_curr),
    .nochg  (in_nochg),
    .status (status),
    .sum    (sum)
  );

  idbm_mean #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_mean (
    .clk     (clk),
    .load    (load),
    .status  (status),
    .sum     (sum),
    .fault   (bounce_fault),
    .full    (window_full),
    .average (window_average)
  );

  // A result without a full window always reports a zero mean.
  `IDBM_ASSERT(a_average_zero_when_not_full,
    (out_valid && !window_full) |-> (window_average == '0))

endmodule

/* rtl/idbm_track.sv */
`timescale 1ns / 1ps
// Window and counter state of the bounce monitor, updated once per step.
// Depends on idbm_pkg and ir_drop_bounce_monitor_assert.svh.
`include "ir_drop_bounce_monitor_assert.svh"

module idbm_track import idbm_pkg::*; #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  idbm_cfg_t                cfg,
  input  logic                     step,
  input  logic [VOLT_W-1:0]        volt,
  input  logic signed [CURR_W-1:0] curr,
  input  logic                     nochg,
  output idbm_status_t             status,
  output logic [VOLT_W+$clog2(WINDOW_LEN)-1:0] sum
);

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int SUM_W  = VOLT_W + SLOT_W;
  localparam int CMP_W  = SUM_W + 2;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);
  localparam logic [CMP_W-1:0]  LEN_CMP   = CMP_W'(WINDOW_LEN);

  logic [VOLT_W-1:0]        window [WINDOW_LEN];
  logic signed [CURR_W-1:0] prev_curr, prev_curr_next;
  logic [SUM_W-1:0]         sum_next;
  logic [SLOT_W-1:0]        slot, slot_next;
  logic                     full_mark, full_mark_next;
  logic [COUNT_W-1:0]       ready_count, ready_count_next;
  logic [COUNT_W-1:0]       abnormal_run, abnormal_run_next;
  logic                     fault_sticky, fault_sticky_next;

  logic [CURR_W:0]   diff;
  logic [CURR_W:0]   mag;
  logic              clear_now;
  logic              full_now;
  logic [SUM_W-1:0]  sum_kept;
  logic [SUM_W-1:0]  sum_new;
  logic [LIFT_W-1:0] lifted;
  logic [CMP_W-1:0]  lifted_scaled;
  logic              is_ready;
  logic              is_below;
  logic [COUNT_W-1:0] ready_inc;
  logic [COUNT_W-1:0] abnormal_inc;
  logic [COUNT_W-1:0] abnormal_step;

  assign diff = {prev_curr[CURR_W-1], prev_curr} - {curr[CURR_W-1], curr};
  assign mag  = diff[CURR_W] ? ((CURR_W+1)'(0) - diff) : diff;

  // A large current jump, an absent charger or a discharge restarts the window.
  assign clear_now = (mag > (CURR_W+1)'(cfg.step_limit)) || nochg ||
                     (!curr[CURR_W-1] && (curr != '0));

  assign full_now = full_mark || (slot == LAST_SLOT);
  assign sum_kept = full_mark ? (sum - SUM_W'(window[slot])) : sum;
  assign sum_new  = sum_kept + SUM_W'(volt);
  assign lifted   = LIFT_W'(volt) + LIFT_W'(cfg.margin);

  // Compare against the scaled sample instead of the truncated mean:
  // lifted > floor(sum/N) exactly when sum < lifted*N, and
  // lifted < floor(sum/N) exactly when (lifted+1)*N <= sum.
  assign lifted_scaled = CMP_W'(lifted) * LEN_CMP;
  assign is_ready      = CMP_W'(sum_new) < lifted_scaled;
  assign is_below      = (lifted_scaled + LEN_CMP) <= CMP_W'(sum_new);

  assign ready_inc     = (ready_count == COUNT_CEIL) ? ready_count : ready_count + 8'd1;
  assign abnormal_inc  = (abnormal_run == COUNT_CEIL) ? abnormal_run : abnormal_run + 8'd1;
  assign abnormal_step = (is_below && (ready_count > cfg.count_limit)) ? abnormal_inc : '0;

  always_comb begin
    prev_curr_next    = prev_curr;
    sum_next          = sum;
    slot_next         = slot;
    full_mark_next    = full_mark;
    ready_count_next  = ready_count;
    abnormal_run_next = abnormal_run;
    fault_sticky_next = fault_sticky;
    if (step) begin
      prev_curr_next = curr;
      if (clear_now) begin
        sum_next          = '0;
        slot_next         = '0;
        full_mark_next    = 1'b0;
        ready_count_next  = '0;
        abnormal_run_next = '0;
      end else begin
        sum_next       = sum_new;
        slot_next      = (slot == LAST_SLOT) ? '0 : slot + SLOT_W'(1);
        full_mark_next = full_now;
        if (full_now) begin
          if (is_ready) begin
            ready_count_next = ready_inc;
          end else begin
            abnormal_run_next = abnormal_step;
            if (abnormal_step > cfg.count_limit) begin
              fault_sticky_next = 1'b1;
            end
          end
        end else if (abnormal_run > cfg.count_limit) begin
          fault_sticky_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_curr    <= '0;
      sum          <= '0;
      slot         <= '0;
      full_mark    <= 1'b0;
      ready_count  <= '0;
      abnormal_run <= '0;
      fault_sticky <= 1'b0;
    end else begin
      prev_curr    <= prev_curr_next;
      sum          <= sum_next;
      slot         <= slot_next;
      full_mark    <= full_mark_next;
      ready_count  <= ready_count_next;
      abnormal_run <= abnormal_run_next;
      fault_sticky <= fault_sticky_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && !clear_now) begin
      window[slot] <= volt;
    end
  end

  assign status.full  = full_mark;
  assign status.fault = fault_sticky;

  // The counters only move while the window is full.
  `IDBM_ASSERT(a_counts_idle_when_not_full,
    !full_mark |-> (ready_count == '0 && abnormal_run == '0))
  `IDBM_ASSERT_NEXT(a_full_until_clear, step && !clear_now && full_mark, full_mark)
  `IDBM_ASSERT_NEXT(a_fault_is_sticky, fault_sticky, fault_sticky)

endmodule

/* rtl/idbm_mean.sv */
`timescale 1ns / 1ps
// Result register of the bounce monitor with the window mean computed by a
// reciprocal multiply. Depends on idbm_pkg.
module idbm_mean import idbm_pkg::*; #(
  parameter int WINDOW_LEN = 10
) (
  input  logic               clk,
  input  logic               load,
  input  idbm_status_t       status,
  input  logic [VOLT_W+$clog2(WINDOW_LEN)-1:0] sum,
  output logic               fault,
  output logic               full,
  output logic [VOLT_W-1:0]  average
);

  localparam int LEN_LOG   = $clog2(WINDOW_LEN);
  localparam int SUM_W     = VOLT_W + LEN_LOG;
  localparam int DIV_SHIFT = SUM_W + LEN_LOG;
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP_POW  = 64'd1 << DIV_SHIFT;
  localparam logic [63:0] RECIP_WIDE = (RECIP_POW + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

  logic [PROD_W-1:0] product;
  logic [VOLT_W-1:0] quotient;

  // The rounded-up reciprocal gives the exact floor for every sum of this width.
  assign product  = PROD_W'(sum) * PROD_W'(RECIP);
  assign quotient = product[DIV_SHIFT +: VOLT_W];

  always_ff @(posedge clk) begin
    if (load) begin
      fault   <= status.fault;
      full    <= status.full;
      average <= status.full ? quotient : '0;
    end
  end

endmodule

/* verif/ir_drop_bounce_monitor_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of ir_drop_bounce_monitor: directed and random battery samples
// with a sample-by-sample model of the bounce window. Depends on idbm_pkg and the RTL top.
module ir_drop_bounce_monitor_test import idbm_pkg::*; ();

  localparam int WIN_LEN = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic             fault;
    logic             full;
    logic [VOLT_W-1:0] average;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [VOLT_W-1:0] cell_voltage = '0;
  logic signed [CURR_W-1:0] cell_current = '0;
  logic no_charge = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic bounce_fault;
  logic window_full;
  logic [VOLT_W-1:0] window_average;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ir_drop_bounce_monitor #(.WINDOW_LEN(WIN_LEN)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cell_voltage(cell_voltage), .cell_current(cell_current), .no_charge(no_charge),
    .out_valid(out_valid), .out_stall(out_stall),
    .bounce_fault(bounce_fault), .window_full(window_full), .window_average(window_average),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the monitor state and its registers.
  int unsigned lim_step;
  int unsigned lim_margin;
  int unsigned lim_count;
  logic signed [CURR_W-1:0] prev_amps;
  int unsigned volt_hist [WIN_LEN];
  int unsigned hist_sum;
  int unsigned hist_slot;
  logic hist_full;
  int unsigned ready_cnt;
  int unsigned abnormal_cnt;
  logic fault_seen;

  status_t status_expected [$];
  int error_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;

  task automatic clear_history();
    hist_sum = 0;
    hist_slot = 0;
    hist_full = 1'b0;
    ready_cnt = 0;
    abnormal_cnt = 0;
  endtask

  task automatic reset_model();
    lim_step = STEP_LIMIT_RST;
    lim_margin = MARGIN_RST;
    lim_count = COUNT_RST;
    prev_amps = '0;
    foreach (volt_hist[i]) volt_hist[i] = 0;
    clear_history();
    fault_seen = 1'b0;
  endtask

  task automatic predict_status(input logic [VOLT_W-1:0] volt,
                                input logic signed [CURR_W-1:0] amps, input logic nochg);
    int diff;
    int unsigned mag;
    int unsigned lifted;
    int unsigned mean;
    int unsigned slot;
    status_t want;
    mean = 0;
    diff = int'(prev_amps) - int'(amps);
    mag = (diff < 0) ? -diff : diff;
    if (mag > lim_step || nochg || amps > 0) begin
      clear_history();
      prev_amps = amps;
    end else begin
      slot = (hist_slot < WIN_LEN) ? hist_slot : 0;
      if (hist_full) hist_sum -= volt_hist[slot];
      else if (slot == WIN_LEN - 1) hist_full = 1'b1;
      volt_hist[slot] = volt;
      hist_sum += volt;
      hist_slot = (slot + 1) % WIN_LEN;
      prev_amps = amps;
      if (hist_full) begin
        lifted = int'(volt) + lim_margin;
        mean = hist_sum / WIN_LEN;
        if (lifted > mean) begin
          if (ready_cnt < COUNT_CEIL) ready_cnt++;
        end else begin
          if (lifted < mean && ready_cnt > lim_count) begin
            if (abnormal_cnt < COUNT_CEIL) abnormal_cnt++;
          end else begin
            abnormal_cnt = 0;
          end
          if (abnormal_cnt > lim_count) fault_seen = 1'b1;
        end
      end else if (abnormal_cnt > lim_count) begin
        fault_seen = 1'b1;
      end
    end
    want.fault = fault_seen;
    want.full = hist_full;
    want.average = mean[VOLT_W-1:0];
    status_expected.push_back(want);
  endtask

  // One sample transaction; bursts of back-to-back samples are separated by random gaps, which may be empty.
  task automatic send_sample(input logic [VOLT_W-1:0] volt,
                             input logic signed [CURR_W-1:0] amps, input logic nochg);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(7, 25);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    cell_voltage <= volt;
    cell_current <= amps;
    no_charge <= nochg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_status(volt, amps, nochg);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (status_expected.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_STEP_LIMIT: lim_step = data[LIMIT_W-1:0];
      REG_MARGIN:     lim_margin = data[MARGIN_W-1:0];
      REG_COUNT:      lim_count = data[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // Writes every register, plus the unused index, while the block is idle.
  task automatic set_config(input logic [CFG_DATA_W-1:0] step, input logic [CFG_DATA_W-1:0] margin,
                            input logic [CFG_DATA_W-1:0] count);
    drain_results();
    write_reg(REG_STEP_LIMIT, step);
    write_reg(REG_MARGIN, margin);
    write_reg(REG_COUNT, count);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    int k;
    send_sample('0, '0, 1'b0);
    send_sample('1, {1'b1, {(CURR_W-1){1'b0}}}, 1'b0);
    send_sample(VOLT_W'(4500000), {1'b0, {(CURR_W-1){1'b1}}}, 1'b0);
    send_sample(VOLT_W'(100), -CURR_W'(5), 1'b1);
    for (k = 0; k < WIN_LEN + 2; k++) send_sample(VOLT_W'(3800000), -CURR_W'(1000), 1'b0);
    // With no margin a steady voltage equals the mean exactly.
    set_config(STEP_LIMIT_RST, '0, CFG_DATA_W'(COUNT_RST));
    send_sample(VOLT_W'(3800000), -CURR_W'(1000), 1'b0);
    send_sample(VOLT_W'(3800000), -CURR_W'(1000), 1'b0);
    send_sample('0, -CURR_W'(1000), 1'b0);
    // A step of exactly the limit keeps the window; one more clears it.
    send_sample(VOLT_W'(3800000), -CURR_W'(26000), 1'b0);
    send_sample(VOLT_W'(3800000), -CURR_W'(51001), 1'b0);
    drain_results();
  endtask

  // Drives the ready count up to its ceiling, then a falling voltage sets the fault.
  task automatic test_counter_saturation();
    int k;
    logic signed [CURR_W-1:0] load;
    load = -CURR_W'(300000);
    set_config(STEP_LIMIT_RST, CFG_DATA_W'(100), CFG_DATA_W'(COUNT_CEIL - 8'd1));
    for (k = 0; k < 280; k++) send_sample(VOLT_W'(4400000), load, 1'b0);
    for (k = 0; k < 280; k++) send_sample(VOLT_W'(4400000 - 1000 * (k + 1)), load, 1'b0);
    drain_results();
  endtask

  // Mostly well-formed discharge-free episodes with steady, noisy or dipping voltage,
  // mixed with raw noise samples and broken sequences.
  task automatic test_random_traffic(input int n_items);
    int sent, len, i, kind, base_v, jitter_max, dip, cur_i, step, v_i;
    logic nc;
    logic signed [CURR_W-1:0] amps;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        send_sample(VOLT_W'($urandom), CURR_W'($urandom), 1'($urandom));
        sent++;
      end else begin
        len = $urandom_range(12, 45);
        base_v = (kind == 2) ? $urandom_range(1000000, 8000000) : $urandom_range(2800000, 4400000);
        jitter_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5000);
        dip = 0;
        step = (lim_step < 6000) ? lim_step : 6000;
        cur_i = int'(prev_amps);
        if (cur_i > 0) cur_i = -int'($urandom_range(0, 2000000));
        for (i = 0; i < len; i++) begin
          if (i >= WIN_LEN && dip == 0 && $urandom_range(0, 5) == 0)
            dip = $urandom_range(0, 250000);
          else if (dip != 0 && $urandom_range(0, 7) == 0)
            dip = 0;
          v_i = base_v - dip + int'($urandom_range(0, jitter_max));
          cur_i = cur_i + int'($urandom_range(0, 2 * step)) - step;
          if (cur_i > 0) cur_i = 0;
          if (cur_i < -8388608) cur_i = -8388608;
          amps = CURR_W'(cur_i);
          nc = 1'b0;
          if ($urandom_range(0, 39) == 0) begin
            case ($urandom_range(0, 2))
              0: nc = 1'b1;
              1: amps = CURR_W'($urandom_range(1, 8388607));
              default: amps = (cur_i - int'(lim_step) - 1 >= -8388608) ?
                              CURR_W'(cur_i - int'(lim_step) - 1) : CURR_W'(1);
            endcase
          end
          send_sample(VOLT_W'(v_i), amps, nc);
          sent++;
          if ($urandom_range(0, 149) == 0) drain_results();
        end
      end
    end
    drain_results();
  endtask

  // Receiver stall pattern: segments of never, light, heavy or periodic stalling.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_left % 5) < 2;
    endcase
  end

  always @(posedge clk) begin : result_check
    status_t want;
    if (!rst && out_valid && !out_stall) begin
      if (status_expected.size() == 0) begin
        $display("%0t: unexpected result fault=%0b full=%0b average=%0d", $time,
                 bounce_fault, window_full, window_average);
        error_count++;
      end else begin
        want = status_expected.pop_front();
        if (bounce_fault !== want.fault) begin
          $display("%0t: bounce_fault expected %0b actual %0b", $time, want.fault, bounce_fault);
          error_count++;
        end
        if (window_full !== want.full) begin
          $display("%0t: window_full expected %0b actual %0b", $time, want.full, window_full);
          error_count++;
        end
        if (window_average !== want.average) begin
          $display("%0t: window_average expected %0d actual %0d", $time,
                   want.average, window_average);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** ir_drop_bounce_monitor: FAILED **");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_config(STEP_LIMIT_RST, CFG_DATA_W'(MARGIN_RST), CFG_DATA_W'(COUNT_CEIL));
    test_random_traffic(330);
    test_counter_saturation();
    set_config('0, '0, '0);
    test_random_traffic(300);
    set_config('1, '1, CFG_DATA_W'(3));
    test_random_traffic(300);
    set_config(CFG_DATA_W'($urandom_range(1000, 30000)), CFG_DATA_W'($urandom_range(0, 5000)),
               CFG_DATA_W'($urandom_range(0, 12)));
    test_random_traffic(330);
    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("** ir_drop_bounce_monitor: PASSED **");
    end else begin
      $display("** ir_drop_bounce_monitor: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/idbm_pkg.sv
rtl/idbm_track.sv
rtl/idbm_mean.sv
rtl/ir_drop_bounce_monitor.sv
verif/ir_drop_bounce_monitor_test.sv
